### sv/static_model_arithmetic_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the static model arithmetic encoder
// Implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STATIC_MODEL_ARITHMETIC_ENCODER_TOP_ASSERT_SVH
`define STATIC_MODEL_ARITHMETIC_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication
`define SMAE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SMAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/smae_pkg.sv
// ----------------------------------------------------------------------------
// Static model arithmetic encoder package
// Widths, model constants, queue entry types and model lookup functions.
// ----------------------------------------------------------------------------
package smae_pkg;

   // Message and field widths
   localparam int SYM_W             = 5;
   localparam int NUM_SYM_MAX       = 5;
   localparam int CODE_W            = 32;
   localparam int LEN_W             = 6;
   localparam int REQ_TDATA_W       = 32;
   localparam int RSP_TDATA_W       = 40;
   localparam int DEF_MSG_SYMBOLS   = 5;
   localparam int DEF_MAX_CODE_BITS = 32;

   // Interval arithmetic: 100^5 times two still fits
   localparam int VAL_W  = 35;
   localparam int PROB_W = 7;
   localparam int SCALE  = 100;

   // Cumulative model in hundredths
   localparam int SYM_MIN   = 10;
   localparam int SYM_MAX   = 20;
   localparam int FIRST_W   = 71;
   localparam int SLOT_BASE = 71;
   localparam int SLOT_W    = 2;
   localparam int TOP_BASE  = 89;
   localparam int TOP_W     = 11;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef logic [VAL_W-1:0]  val_type;
   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [PROB_W-1:0] prob_type;

   typedef struct packed {
      logic    bad;
      val_type low;
      val_type high;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Denominator of the final interval
   function automatic val_type pow_scale(input int n);
      val_type p;
      p = val_type'(1);
      for (int i = 0; i < n; i++) begin
         p = val_type'(p * val_type'(SCALE));
      end
      return p;
   endfunction

   function automatic logic sym_valid(input sym_type s);
      return (s >= sym_type'(SYM_MIN)) && (s <= sym_type'(SYM_MAX));
   endfunction

   // Lower cumulative bound of a valid symbol
   function automatic prob_type cum_low(input sym_type s);
      prob_type r;
      case (s)
         sym_type'(SYM_MIN): r = '0;
         sym_type'(SYM_MAX): r = prob_type'(TOP_BASE);
         default:            r = prob_type'(SLOT_BASE + SLOT_W * (int'(s) - SYM_MIN - 1));
      endcase
      return r;
   endfunction

   // Width of a valid symbol's slot
   function automatic prob_type cum_width(input sym_type s);
      prob_type r;
      case (s)
         sym_type'(SYM_MIN): r = prob_type'(FIRST_W);
         sym_type'(SYM_MAX): r = prob_type'(TOP_W);
         default:            r = prob_type'(SLOT_W);
      endcase
      return r;
   endfunction

endpackage

### sv/static_model_arithmetic_encoder_top.sv
// ----------------------------------------------------------------------------
// Static model arithmetic encoder
// Encodes a message of symbols 10 to 20 against a fixed model into a code.
// ----------------------------------------------------------------------------
// Use:
//   req channel: one transaction carries a whole message, five 5-bit
//   symbols in req_tdata. rsp channel: one transaction per message with the
//   right-aligned code and its length in rsp_tdata, and rsp_tuser set when a
//   symbol lies outside 10 to 20 (code and length are then zero).
//   Front end: accept, a narrowing step for each symbol and a post to a
//   two-entry queue. Back end: pop, an expansion step for each bit, an
//   extension step for each bit of the longer prefix and a step to close
//   the extension, then a load of the result. The front end can accept a
//   new message while the back end still works on the one before.
//   Reset empties the queue, returns both ends to idle and drops any held
//   result. While the receiver stalls the result is held in the output
//   register, the back end waits, and the front end keeps accepting until
//   the queue fills.
// ----------------------------------------------------------------------------
module static_model_arithmetic_encoder_top #(
   parameter int MSG_SYMBOLS   = smae_pkg::DEF_MSG_SYMBOLS,
   parameter int MAX_CODE_BITS = smae_pkg::DEF_MAX_CODE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sym_a, sym_b, sym_c, sym_d, sym_e (5 bits each), zero fill
   input  logic [smae_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // code_bits (32), code_length (6), zero fill
   output logic [smae_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // bad_symbol
   output logic                             rsp_tuser
);
   import smae_pkg::*;

   logic       q_wr;
   logic       q_rd;
   qentry_type q_wdata;
   qentry_type q_rdata;
   qstat_type  q_stat;

   // Accept and narrow
   smae_front #(
      .MSG_SYMBOLS (MSG_SYMBOLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_wr       (q_wr),
      .q_wdata    (q_wdata),
      .q_stat     (q_stat)
   );

   // Decouple the two halves
   smae_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .wdata (q_wdata),
      .rd    (q_rd),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // Generate the code bits
   smae_back #(
      .MSG_SYMBOLS   (MSG_SYMBOLS),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_rd       (q_rd),
      .q_rdata    (q_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sv/smae_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts a message, checks its symbols and, when all are valid, narrows the
// interval one symbol per cycle, then posts the bounds to the queue.
// ----------------------------------------------------------------------------
module smae_front #(
   parameter int MSG_SYMBOLS = smae_pkg::DEF_MSG_SYMBOLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [smae_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           q_wr,
   output smae_pkg::qentry_type           q_wdata,
   input  smae_pkg::qstat_type            q_stat
);
   import smae_pkg::*;

   localparam int STEP_W = $clog2(MSG_SYMBOLS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_NARROW, ST_PUSH} state_type;

   state_type         state_ff;
   sym_type           sym_ff [NUM_SYM_MAX];
   logic [STEP_W-1:0] step_ff;
   val_type           lo_ff;
   val_type           wid_ff;
   logic              bad_ff;

   logic     bad_in;
   prob_type cl;
   prob_type cw;
   val_type  lo_in;
   val_type  wid_in;

   // Flag any used symbol outside the model
   always_comb begin
      bad_in = 1'b0;
      for (int i = 0; i < MSG_SYMBOLS; i++) begin
         if (!sym_valid(req_tdata[i*SYM_W +: SYM_W])) begin
            bad_in = 1'b1;
         end
      end
   end

   // One narrowing step on the head symbol
   assign cl     = cum_low(sym_ff[0]);
   assign cw     = cum_width(sym_ff[0]);
   assign lo_in  = lo_ff * val_type'(SCALE) + val_type'(cl) * wid_ff;
   assign wid_in = wid_ff * val_type'(cw);

   assign req_tready    = (state_ff == ST_IDLE);
   assign q_wr          = (state_ff == ST_PUSH) && !q_stat.full;
   assign q_wdata.bad   = bad_ff;
   assign q_wdata.low   = lo_ff;
   assign q_wdata.high  = lo_ff + wid_ff;

   // Sequence accept, narrowing and posting
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  for (int i = 0; i < NUM_SYM_MAX; i++) begin
                     sym_ff[i] <= req_tdata[i*SYM_W +: SYM_W];
                  end
                  bad_ff   <= bad_in;
                  lo_ff    <= '0;
                  wid_ff   <= val_type'(1);
                  step_ff  <= '0;
                  state_ff <= bad_in ? ST_PUSH : ST_NARROW;
               end
            end
            ST_NARROW: begin
               lo_ff   <= lo_in;
               wid_ff  <= wid_in;
               step_ff <= step_ff + 1'b1;
               for (int i = 0; i < NUM_SYM_MAX - 1; i++) begin
                  sym_ff[i] <= sym_ff[i+1];
               end
               if (step_ff == STEP_W'(MSG_SYMBOLS - 1)) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!q_stat.full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### sv/smae_queue.sv
// ----------------------------------------------------------------------------
// Encoder interval queue
// Short first-in first-out store of interval bounds between front and back.
// ----------------------------------------------------------------------------
module smae_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr,
   input  smae_pkg::qentry_type wdata,
   input  logic                 rd,
   output smae_pkg::qentry_type rdata,
   output smae_pkg::qstat_type  stat
);
   import smae_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   qentry_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rdata      = entry_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr) begin
            entry_ff[wr_ptr_ff] <= wdata;
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({wr, rd})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### sv/smae_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Expands the interval bounds in binary one bit per cycle, extends the lower
// and upper prefixes side by side, picks the code and holds it for output.
// ----------------------------------------------------------------------------
module smae_back #(
   parameter int MSG_SYMBOLS   = smae_pkg::DEF_MSG_SYMBOLS,
   parameter int MAX_CODE_BITS = smae_pkg::DEF_MAX_CODE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  smae_pkg::qstat_type             q_stat,
   output logic                            q_rd,
   input  smae_pkg::qentry_type            q_rdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smae_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser
);
   import smae_pkg::*;

   localparam val_type DEN   = pow_scale(MSG_SYMBOLS);
   localparam val_type DEN2  = val_type'(DEN * val_type'(2));
   localparam int      ACC_W = MAX_CODE_BITS;
   localparam int      CNT_W = $clog2(MAX_CODE_BITS + 1);
   localparam int      SUM_W = CNT_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_EXTEND, ST_FINISH} state_type;

   state_type         state_ff;
   val_type           l_ff;
   val_type           u_ff;
   val_type           tl_ff;
   val_type           tu_ff;
   logic [ACC_W-1:0]  lbits_ff;
   logic [ACC_W-1:0]  ubits_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  kl_ff;
   logic [CNT_W-1:0]  ku_ff;
   logic              bad_ff;
   logic              ext_ff;
   logic              uinf_ff;
   logic              out_valid_ff;
   logic [CODE_W-1:0] out_bits_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic              out_bad_ff;

   val_type          l2, u2, l_in, u_in;
   logic             bl, bu;
   logic [CNT_W-1:0] n_in;
   logic             exp_stop;
   logic             lo_go, up_go;
   logic [SUM_W-1:0] kl_fin, ku_fin, len_lo, len_up, len_sel;
   logic             use_upper;
   logic [ACC_W-1:0] bits_sel;
   logic             out_free;
   logic             out_valid_in;

   // One binary expansion step of both bounds; an upper bound of one stays one
   assign l2   = {l_ff[VAL_W-2:0], 1'b0};
   assign bl   = (l2 >= DEN);
   assign l_in = bl ? l2 - DEN : l2;
   assign u2   = {u_ff[VAL_W-2:0], 1'b0};
   assign bu   = (u2 >= DEN);
   assign u_in = (u2 == DEN2) ? DEN : (bu ? u2 - DEN : u2);
   assign n_in = n_ff + 1'b1;

   assign exp_stop = (bl != bu) || ((l_in == '0) && (u_in == '0)) ||
                     (n_in == CNT_W'(MAX_CODE_BITS));

   // Prefix extension runs while the bound is not reached and room is left
   assign lo_go = (tl_ff < DEN) &&
                  (SUM_W'(n_ff) + SUM_W'(kl_ff) < SUM_W'(MAX_CODE_BITS));
   assign up_go = !uinf_ff && (tu_ff < DEN) &&
                  (SUM_W'(n_ff) + SUM_W'(ku_ff) < SUM_W'(MAX_CODE_BITS));

   // Choose the lower code without extension, with an unbounded upper one or when strictly shorter, else the upper one
   assign kl_fin    = SUM_W'(kl_ff) + SUM_W'(tl_ff < DEN);
   assign ku_fin    = SUM_W'(ku_ff) + SUM_W'(!uinf_ff && (tu_ff < DEN));
   assign use_upper = ext_ff && !(uinf_ff || (kl_fin < ku_fin));
   assign len_lo    = SUM_W'(n_ff) + SUM_W'(kl_ff);
   assign len_up    = SUM_W'(n_ff) + SUM_W'(ku_ff);
   assign len_sel   = use_upper ? len_up : len_lo;
   assign bits_sel  = use_upper ? ubits_ff : lbits_ff;

   // Raise the result on load, drop it once taken
   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_valid_in = ((state_ff == ST_FINISH) && out_free) ||
                         (out_valid_ff && !rsp_tready);

   assign q_rd       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - CODE_W - LEN_W){1'b0}}, out_len_ff, out_bits_ff};
   assign rsp_tuser  = out_bad_ff;

   // Sequence pop, expansion, extension and result hand-off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  l_ff     <= q_rdata.low;
                  u_ff     <= q_rdata.high;
                  bad_ff   <= q_rdata.bad;
                  lbits_ff <= '0;
                  ubits_ff <= '0;
                  n_ff     <= '0;
                  kl_ff    <= '0;
                  ku_ff    <= '0;
                  ext_ff   <= 1'b0;
                  uinf_ff  <= 1'b0;
                  state_ff <= q_rdata.bad ? ST_FINISH : ST_EXPAND;
               end
            end
            ST_EXPAND: begin
               l_ff     <= l_in;
               u_ff     <= u_in;
               lbits_ff <= {lbits_ff[ACC_W-2:0], bl};
               ubits_ff <= {ubits_ff[ACC_W-2:0], bu};
               n_ff     <= n_in;
               if (exp_stop) begin
                  if (l_in != '0) begin
                     ext_ff   <= 1'b1;
                     tl_ff    <= DEN - l_in;
                     tu_ff    <= u_in;
                     uinf_ff  <= (u_in == '0);
                     state_ff <= ST_EXTEND;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_EXTEND: begin
               if (lo_go) begin
                  tl_ff    <= {tl_ff[VAL_W-2:0], 1'b0};
                  kl_ff    <= kl_ff + 1'b1;
                  lbits_ff <= {lbits_ff[ACC_W-2:0], 1'b1};
               end
               if (up_go) begin
                  tu_ff    <= {tu_ff[VAL_W-2:0], 1'b0};
                  ku_ff    <= ku_ff + 1'b1;
                  ubits_ff <= {ubits_ff[ACC_W-2:0], 1'b0};
               end
               if (!lo_go && !up_go) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_bad_ff   <= bad_ff;
                  out_bits_ff  <= bad_ff ? '0 : bits_sel[CODE_W-1:0];
                  out_len_ff   <= bad_ff ? '0 : len_sel[LEN_W-1:0];
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### sv/smae_checker.sv
// ----------------------------------------------------------------------------
// Encoder port checker
// Watches the top-level ports for result holding and code consistency.
// ----------------------------------------------------------------------------
`include "static_model_arithmetic_encoder_top_assert.svh"

module smae_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [smae_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   // Take no new message straight after an accepted one
   `SMAE_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready, "input ready right after accept")

   // Hold a stalled result
   `SMAE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Error results carry no code
   `SMAE_ASSERT_IMPLY(a_err_empty, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "error result carries a code")

   // A good code has a length and no bits above it
   `SMAE_ASSERT_IMPLY(a_code_fits, clock, reset, rsp_tvalid && !rsp_tuser, (rsp_tdata[37:32] != '0) && ((rsp_tdata[31:0] >> rsp_tdata[37:32]) == '0), "code bits beyond length")

   // No result straight after reset
   `SMAE_ASSERT_IMPLY(a_rst_quiet, clock, 1'b0, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

bind static_model_arithmetic_encoder_top smae_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
